// ----- sv/imq_pkg.sv -----
// Package for the indexed min priority queue unit.
// Holds sizes, request and status codes, item structs and the sequencer states.
// Depends on nothing.
package imq_pkg;

	localparam int NumKeys   = 256;
	localparam int KeyBits   = 8;
	localparam int ValueBits = 32;
	localparam int CountBits = 9;

	typedef enum logic [2:0] {
		REQ_INSERT   = 3'd0,
		REQ_DELETE   = 3'd1,
		REQ_UPDATE   = 3'd2,
		REQ_DECREASE = 3'd3,
		REQ_INCREASE = 3'd4,
		REQ_POLL     = 3'd5,
		REQ_PEEK     = 3'd6,
		REQ_LOOKUP   = 3'd7
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_PRESENT     = 2'd1,
		ST_NOT_PRESENT = 2'd2,
		ST_EMPTY       = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]                  req_type;
		logic [KeyBits-1:0]          key_index;
		logic signed [ValueBits-1:0] new_value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [KeyBits-1:0]          out_key;
		logic signed [ValueBits-1:0] out_value;
		logic                        key_held;
		logic [CountBits-1:0]        entry_count;
	} rsp_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_KEY,
		S_RD_KEY_W,
		S_DISPATCH,
		S_RM_RD,
		S_RM_RD_W,
		S_RM_SWAP,
		S_SIFT_START,
		S_RD_CUR,
		S_RD_CUR_W,
		S_RD_CUR_V,
		S_RD_CUR_VW,
		S_DN_RD_L,
		S_DN_RD_LW,
		S_DN_RD_LV,
		S_DN_RD_LVW,
		S_DN_RD_R,
		S_DN_RD_RW,
		S_DN_RD_RV,
		S_DN_RD_RVW,
		S_DN_DECIDE,
		S_UP_RD,
		S_UP_RD_W,
		S_UP_RD_V,
		S_UP_RD_VW,
		S_UP_DECIDE,
		S_SWAP_A,
		S_SWAP_B,
		S_DONE
	} seq_state_t;

endpackage

// ----- sv/indexed_min_priority_queue_unit.sv -----
// Top level of the indexed min priority queue unit: an indexed binary min-heap.
// Holds the sequencer, the key and slot maps and the value store as memories.
// Depends on imq_pkg.
//
// Usage: drive req with an item and raise start while busy is low; the item
// is taken at that edge and busy rises at once. When the work ends, rsp_valid
// is high for exactly one cycle with the result item, and busy falls in the
// same cycle, so the next item may be started at the edge that takes the
// result. The receiver cannot stall; a result must be taken in its cycle.
// Each memory has a single read port and the one comparator is shared, so a
// request runs as a sequence of reads and compares. A sift down level reads
// the keys and values of up to two children, compares each with the best so
// far and swaps in S_SWAP_A then S_SWAP_B; a sift up level reads the parent's
// key and value and compares once. A sift crosses up to eight levels; the
// worst case is an update that sinks from the root of a full heap. Items are
// processed one at a time. Reset clears the valid bits and the entry count;
// the three maps are not reset; data read at unheld keys or empty slots is unused.
module indexed_min_priority_queue_unit
	import imq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_item_t req,
	output logic      busy,
	output logic      rsp_valid,
	output rsp_item_t rsp
);

	logic [KeyBits-1:0]          pos_mem [NumKeys];
	logic [KeyBits-1:0]          key_mem [NumKeys];
	logic signed [ValueBits-1:0] val_mem [NumKeys];
	logic [NumKeys-1:0]          valid_q;
	logic [CountBits-1:0]        size_q;

	seq_state_t state_q, state_d;
	req_item_t  req_q;

	// Memory ports: one read address per memory, registered read data.
	logic [KeyBits-1:0]          pos_raddr, key_raddr, val_raddr;
	logic [KeyBits-1:0]          pos_rdata, key_rdata;
	logic signed [ValueBits-1:0] val_rdata;
	logic                        pos_we, key_we, val_we;
	logic [KeyBits-1:0]          pos_waddr, pos_wdata, key_waddr, key_wdata, val_waddr;
	logic signed [ValueBits-1:0] val_wdata;

	always_ff @(posedge clk) begin
		pos_rdata <= pos_mem[pos_raddr];
		key_rdata <= key_mem[key_raddr];
		val_rdata <= val_mem[val_raddr];
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
	end

	// Sift working registers.
	logic [KeyBits-1:0]          cur_p_q, cur_k_q, oth_p_q, oth_k_q, best_p_q, best_k_q;
	logic signed [ValueBits-1:0] cur_v_q, best_v_q, oth_v_q;
	logic                        do_dn_q, do_up_q, going_up_q;
	logic [KeyBits-1:0]          rm_p_q, last_k_q;
	logic                        pk_q;
	logic [1:0]                  status_q;
	logic [KeyBits-1:0]          okey_q;
	logic signed [ValueBits-1:0] oval_q;

	logic [KeyBits-1:0] key8;
	logic               held;
	logic [CountBits:0] lchild;

	// Shared comparator: strict signed less-than.
	logic signed [ValueBits-1:0] cmp_a, cmp_b;
	logic                        cmp_lt;
	assign cmp_lt = cmp_a < cmp_b;

	assign key8   = req_q.key_index;
	assign held   = valid_q[key8];
	assign lchild = {1'b0, cur_p_q, 1'b1};

	// Registered control and data updates.
	logic [KeyBits-1:0]          cur_p_d, cur_k_d, oth_p_d, oth_k_d, best_p_d, best_k_d;
	logic signed [ValueBits-1:0] cur_v_d, best_v_d, oth_v_d, oval_d;
	logic                        do_dn_d, do_up_d, going_up_d, pk_d;
	logic [KeyBits-1:0]          rm_p_d, last_k_d, okey_d;
	logic [1:0]                  status_d;
	logic [CountBits-1:0]        size_d;
	logic [NumKeys-1:0]          valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			size_q  <= size_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		cur_p_q    <= cur_p_d;
		cur_k_q    <= cur_k_d;
		cur_v_q    <= cur_v_d;
		oth_p_q    <= oth_p_d;
		oth_k_q    <= oth_k_d;
		oth_v_q    <= oth_v_d;
		best_p_q   <= best_p_d;
		best_k_q   <= best_k_d;
		best_v_q   <= best_v_d;
		do_dn_q    <= do_dn_d;
		do_up_q    <= do_up_d;
		going_up_q <= going_up_d;
		rm_p_q     <= rm_p_d;
		last_k_q   <= last_k_d;
		pk_q       <= pk_d;
		status_q   <= status_d;
		okey_q     <= okey_d;
		oval_q     <= oval_d;
	end

	always_comb begin
		state_d    = state_q;
		cur_p_d    = cur_p_q;
		cur_k_d    = cur_k_q;
		cur_v_d    = cur_v_q;
		oth_p_d    = oth_p_q;
		oth_k_d    = oth_k_q;
		oth_v_d    = oth_v_q;
		best_p_d   = best_p_q;
		best_k_d   = best_k_q;
		best_v_d   = best_v_q;
		do_dn_d    = do_dn_q;
		do_up_d    = do_up_q;
		going_up_d = going_up_q;
		rm_p_d     = rm_p_q;
		last_k_d   = last_k_q;
		pk_d       = pk_q;
		status_d   = status_q;
		okey_d     = okey_q;
		oval_d     = oval_q;
		size_d     = size_q;
		valid_d    = valid_q;
		pos_raddr  = key8;
		key_raddr  = cur_p_q;
		val_raddr  = key8;
		pos_we     = 1'b0;
		key_we     = 1'b0;
		val_we     = 1'b0;
		pos_waddr  = cur_k_q;
		pos_wdata  = cur_p_q;
		key_waddr  = cur_p_q;
		key_wdata  = cur_k_q;
		val_waddr  = key8;
		val_wdata  = req_q.new_value;
		cmp_a      = cur_v_q;
		cmp_b      = oth_v_q;
		busy       = (state_q != S_IDLE);
		rsp_valid  = 1'b0;
		rsp        = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_RD_KEY;
				end
			end
			S_RD_KEY: begin
				// Read slot and value of the requested key, and the root key.
				pos_raddr = key8;
				val_raddr = key8;
				key_raddr = '0;
				status_d  = ST_OK;
				okey_d    = key8;
				oval_d    = '0;
				do_dn_d   = 1'b0;
				do_up_d   = 1'b0;
				pk_d      = 1'b0;
				state_d   = S_RD_KEY_W;
			end
			S_RD_KEY_W: begin
				cur_p_d = pos_rdata;
				cur_k_d = key8;
				best_k_d = key_rdata;
				oth_v_d = val_rdata;
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (req_type_t'(req_q.req_type))
					REQ_INSERT: begin
						if (held) begin
							status_d = ST_PRESENT;
						end else begin
							val_we   = 1'b1;
							pos_we   = 1'b1;
							pos_waddr = key8;
							pos_wdata = size_q[KeyBits-1:0];
							key_we   = 1'b1;
							key_waddr = size_q[KeyBits-1:0];
							key_wdata = key8;
							valid_d[key8] = 1'b1;
							size_d   = size_q + 1'b1;
							cur_p_d  = size_q[KeyBits-1:0];
							cur_v_d  = req_q.new_value;
							do_up_d  = 1'b1;
							state_d  = S_SIFT_START;
						end
					end
					REQ_DELETE: begin
						if (!held) begin
							status_d = ST_NOT_PRESENT;
						end else begin
							oval_d  = oth_v_q;
							rm_p_d  = cur_p_q;
							state_d = S_RM_RD;
						end
					end
					REQ_UPDATE, REQ_DECREASE, REQ_INCREASE: begin
						if (!held) begin
							status_d = ST_NOT_PRESENT;
						end else begin
							oval_d = oth_v_q;
							cur_v_d = req_q.new_value;
							cmp_a = req_q.new_value;
							cmp_b = oth_v_q;
							if (req_q.req_type == REQ_UPDATE) begin
								do_dn_d = 1'b1;
								do_up_d = 1'b1;
							end else if (req_q.req_type == REQ_DECREASE) begin
								do_up_d = cmp_lt;
							end else begin
								cmp_a = oth_v_q;
								cmp_b = req_q.new_value;
								do_dn_d = cmp_lt;
							end
							if (req_q.req_type == REQ_UPDATE || cmp_lt) begin
								val_we  = 1'b1;
								state_d = S_SIFT_START;
							end
						end
					end
					REQ_POLL, REQ_PEEK: begin
						if (size_q == '0) begin
							status_d = ST_EMPTY;
							okey_d   = '0;
						end else begin
							okey_d  = best_k_q;
							state_d = S_RM_RD;
							pk_d    = 1'b1;
						end
					end
					default: begin
						if (!held) begin
							status_d = ST_NOT_PRESENT;
						end else begin
							oval_d = oth_v_q;
						end
					end
				endcase
			end
			S_RM_RD: begin
				// For poll and peek, fetch the minimum's value; read the last slot's key.
				val_raddr = okey_q;
				key_raddr = size_q[KeyBits-1:0] - 1'b1;
				state_d   = S_RM_RD_W;
			end
			S_RM_RD_W: begin
				if (pk_q) begin
					oval_d = val_rdata;
					rm_p_d = '0;
				end
				last_k_d = key_rdata;
				state_d  = (req_q.req_type == REQ_PEEK) ? S_DONE : S_RM_SWAP;
			end
			S_RM_SWAP: begin
				// Move the last entry into the freed slot.
				key_we    = 1'b1;
				key_waddr = rm_p_q;
				key_wdata = last_k_q;
				pos_we    = 1'b1;
				pos_waddr = last_k_q;
				pos_wdata = rm_p_q;
				valid_d[pk_q ? okey_q : key8] = 1'b0;
				size_d    = size_q - 1'b1;
				cur_p_d   = rm_p_q;
				do_dn_d   = 1'b1;
				do_up_d   = 1'b1;
				if ({1'b0, rm_p_q} < size_q - 1'b1) begin
					state_d = S_RD_CUR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SIFT_START: begin
				state_d = S_RD_CUR;
			end
			S_RD_CUR: begin
				key_raddr = cur_p_q;
				state_d   = S_RD_CUR_W;
			end
			S_RD_CUR_W: begin
				cur_k_d = key_rdata;
				state_d = S_RD_CUR_V;
			end
			S_RD_CUR_V: begin
				val_raddr = cur_k_q;
				state_d   = S_RD_CUR_VW;
			end
			S_RD_CUR_VW: begin
				cur_v_d    = val_rdata;
				going_up_d = !do_dn_q;
				state_d    = do_dn_q ? S_DN_RD_L : S_UP_RD;
			end
			S_DN_RD_L: begin
				best_p_d = cur_p_q;
				best_k_d = cur_k_q;
				best_v_d = cur_v_q;
				if (lchild < {1'b0, size_q}) begin
					key_raddr = lchild[KeyBits-1:0];
					state_d   = S_DN_RD_LW;
				end else begin
					state_d = S_DN_DECIDE;
				end
			end
			S_DN_RD_LW: begin
				oth_k_d = key_rdata;
				oth_p_d = lchild[KeyBits-1:0];
				state_d = S_DN_RD_LV;
			end
			S_DN_RD_LV: begin
				val_raddr = oth_k_q;
				state_d   = S_DN_RD_LVW;
			end
			S_DN_RD_LVW: begin
				cmp_a = val_rdata;
				cmp_b = best_v_q;
				if (cmp_lt) begin
					best_p_d = oth_p_q;
					best_k_d = oth_k_q;
					best_v_d = val_rdata;
				end
				if (lchild + 1'b1 < {1'b0, size_q}) begin
					key_raddr = lchild[KeyBits-1:0] + 1'b1;
					state_d   = S_DN_RD_RW;
				end else begin
					state_d = S_DN_DECIDE;
				end
			end
			S_DN_RD_R: begin
				state_d = S_DN_RD_RW;
			end
			S_DN_RD_RW: begin
				oth_k_d = key_rdata;
				oth_p_d = lchild[KeyBits-1:0] + 1'b1;
				state_d = S_DN_RD_RV;
			end
			S_DN_RD_RV: begin
				val_raddr = oth_k_q;
				state_d   = S_DN_RD_RVW;
			end
			S_DN_RD_RVW: begin
				cmp_a = val_rdata;
				cmp_b = best_v_q;
				if (cmp_lt) begin
					best_p_d = oth_p_q;
					best_k_d = oth_k_q;
					best_v_d = val_rdata;
				end
				state_d = S_DN_DECIDE;
			end
			S_DN_DECIDE: begin
				if (best_p_q != cur_p_q) begin
					oth_p_d = best_p_q;
					oth_k_d = best_k_q;
					state_d = S_SWAP_A;
				end else if (do_up_q) begin
					going_up_d = 1'b1;
					state_d    = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UP_RD: begin
				if (cur_p_q == '0) begin
					state_d = S_DONE;
				end else begin
					key_raddr = (cur_p_q - 1'b1) >> 1;
					oth_p_d   = (cur_p_q - 1'b1) >> 1;
					state_d   = S_UP_RD_W;
				end
			end
			S_UP_RD_W: begin
				oth_k_d = key_rdata;
				state_d = S_UP_RD_V;
			end
			S_UP_RD_V: begin
				val_raddr = oth_k_q;
				state_d   = S_UP_RD_VW;
			end
			S_UP_RD_VW: begin
				oth_v_d = val_rdata;
				state_d = S_UP_DECIDE;
			end
			S_UP_DECIDE: begin
				cmp_a = cur_v_q;
				cmp_b = oth_v_q;
				state_d = cmp_lt ? S_SWAP_A : S_DONE;
			end
			S_SWAP_A: begin
				// Current key goes to the other slot.
				key_we    = 1'b1;
				key_waddr = oth_p_q;
				key_wdata = cur_k_q;
				pos_we    = 1'b1;
				pos_waddr = cur_k_q;
				pos_wdata = oth_p_q;
				state_d   = S_SWAP_B;
			end
			S_SWAP_B: begin
				key_we    = 1'b1;
				key_waddr = cur_p_q;
				key_wdata = oth_k_q;
				pos_we    = 1'b1;
				pos_waddr = oth_k_q;
				pos_wdata = cur_p_q;
				cur_p_d   = oth_p_q;
				state_d   = going_up_q ? S_UP_RD : S_DN_RD_L;
			end
			S_DONE: begin
				rsp_valid       = 1'b1;
				busy            = 1'b0;
				rsp.status      = status_q;
				rsp.out_key     = okey_q;
				rsp.out_value   = oval_q;
				rsp.key_held    = valid_q[key8];
				rsp.entry_count = size_q;
				state_d         = start ? S_RD_KEY : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) size_q <= CountBits'(NumKeys);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("entry count overflow");

	property p_count_matches_valid;
		@(posedge clk) disable iff (!arst_n)
			rsp_valid |-> ($countones(valid_q) == int'(size_q));
	endproperty
	a_count_matches_valid: assert property (p_count_matches_valid)
		else $error("entry count differs from held keys");

	property p_no_result_idle;
		@(posedge clk) disable iff (!arst_n) (state_q == S_IDLE) |-> !rsp_valid;
	endproperty
	a_no_result_idle: assert property (p_no_result_idle) else $error("result while idle");

	property p_fail_keeps_count;
		@(posedge clk) disable iff (!arst_n)
			(rsp_valid && rsp.status != ST_OK) |-> (size_q == $past(size_q));
	endproperty
	a_fail_keeps_count: assert property (p_fail_keeps_count)
		else $error("failed request changed entry count");

endmodule

// ----- verif/tb_indexed_min_priority_queue_unit.sv -----
// Testbench for the indexed min priority queue unit: directed and random requests
// checked against a behavioural indexed min-heap kept alongside the block.
// Depends on imq_pkg and indexed_min_priority_queue_unit.
`timescale 1ns / 100ps

module tb_indexed_min_priority_queue_unit;
	import imq_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      start;
	req_item_t req;
	logic      busy;
	logic      rsp_valid;
	rsp_item_t rsp;

	indexed_min_priority_queue_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	localparam int WatchdogLimit = 20000;

	logic [KeyBits-1:0]          slot_of_key [NumKeys];
	logic [KeyBits-1:0]          key_of_slot [NumKeys];
	logic signed [ValueBits-1:0] prio_of_key [NumKeys];
	bit                          held_key    [NumKeys];
	int                          heap_count;

	req_item_t pending_reqs[$];
	rsp_item_t awaited_rsps[$];
	int        sender_idle_pct;
	int        errors;
	int        sent;
	int        checked;
	int        quiet_cycles;
	bit        stim_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [ValueBits-1:0] slot_prio(int p);
		return prio_of_key[key_of_slot[p]];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [KeyBits-1:0] ka, kb;
		ka = key_of_slot[a];
		kb = key_of_slot[b];
		key_of_slot[a] = kb;
		key_of_slot[b] = ka;
		slot_of_key[kb] = KeyBits'(a);
		slot_of_key[ka] = KeyBits'(b);
	endfunction

	function automatic void sift_up(int p);
		int par;
		while (p > 0) begin
			par = (p - 1) / 2;
			if (!(slot_prio(p) < slot_prio(par))) break;
			swap_slots(p, par);
			p = par;
		end
	endfunction

	function automatic void sift_down(int p);
		int best, j;
		forever begin
			best = p;
			for (j = 2 * p + 1; j < 2 * p + 3 && j < heap_count; j++)
				if (slot_prio(j) < slot_prio(best)) best = j;
			if (best == p) break;
			swap_slots(p, best);
			p = best;
		end
	endfunction

	function automatic void remove_entry(int k);
		int p;
		p = slot_of_key[k];
		heap_count--;
		swap_slots(p, heap_count);
		held_key[k] = 0;
		if (p < heap_count) begin
			sift_down(p);
			sift_up(p);
		end
	endfunction

	function automatic rsp_item_t heap_outcome(req_item_t r);
		rsp_item_t o;
		int k;
		bit held;
		k = r.key_index;
		held = held_key[k];
		o = '0;
		o.status = ST_OK;
		o.out_key = r.key_index;
		case (req_type_t'(r.req_type))
			REQ_INSERT: begin
				if (held) o.status = ST_PRESENT;
				else begin
					prio_of_key[k] = r.new_value;
					held_key[k] = 1;
					slot_of_key[k] = KeyBits'(heap_count);
					key_of_slot[heap_count] = KeyBits'(k);
					heap_count++;
					sift_up(heap_count - 1);
				end
			end
			REQ_DELETE: begin
				if (!held) o.status = ST_NOT_PRESENT;
				else begin
					o.out_value = prio_of_key[k];
					remove_entry(k);
				end
			end
			REQ_UPDATE: begin
				if (!held) o.status = ST_NOT_PRESENT;
				else begin
					o.out_value = prio_of_key[k];
					prio_of_key[k] = r.new_value;
					sift_down(slot_of_key[k]);
					sift_up(slot_of_key[k]);
				end
			end
			REQ_DECREASE: begin
				if (!held) o.status = ST_NOT_PRESENT;
				else begin
					o.out_value = prio_of_key[k];
					if (r.new_value < o.out_value) begin
						prio_of_key[k] = r.new_value;
						sift_up(slot_of_key[k]);
					end
				end
			end
			REQ_INCREASE: begin
				if (!held) o.status = ST_NOT_PRESENT;
				else begin
					o.out_value = prio_of_key[k];
					if (o.out_value < r.new_value) begin
						prio_of_key[k] = r.new_value;
						sift_down(slot_of_key[k]);
					end
				end
			end
			REQ_POLL, REQ_PEEK: begin
				if (heap_count == 0) begin
					o.status = ST_EMPTY;
					o.out_key = '0;
				end else begin
					o.out_key = key_of_slot[0];
					o.out_value = prio_of_key[key_of_slot[0]];
					if (r.req_type == REQ_POLL) remove_entry(key_of_slot[0]);
				end
			end
			default: begin
				if (!held) o.status = ST_NOT_PRESENT;
				else o.out_value = prio_of_key[k];
			end
		endcase
		o.key_held = held_key[k];
		o.entry_count = CountBits'(heap_count);
		return o;
	endfunction

	function automatic req_item_t make_req(req_type_t t, int k, logic [31:0] v);
		req_item_t r;
		r.req_type = t;
		r.key_index = KeyBits'(k);
		r.new_value = v;
		return r;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Keys are mostly drawn from 0 to key_span; a small span makes held keys hit often.
	task automatic add_random(int count, int key_span);
		int i, roll, hi;
		req_type_t t;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30) t = REQ_INSERT;
			else if (roll < 40) t = REQ_DELETE;
			else if (roll < 50) t = REQ_UPDATE;
			else if (roll < 60) t = REQ_DECREASE;
			else if (roll < 70) t = REQ_INCREASE;
			else if (roll < 82) t = REQ_POLL;
			else if (roll < 90) t = REQ_PEEK;
			else t = REQ_LOOKUP;
			hi = ($urandom_range(0, 9) == 0) ? NumKeys - 1 : key_span;
			pending_reqs.push_back(make_req(t, $urandom_range(0, hi), rand_value()));
		end
	endtask

	task automatic run_phase(int idle_pct);
		sender_idle_pct = idle_pct;
		while (pending_reqs.size() != 0 || awaited_rsps.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else if (start && !busy) begin
			void'(pending_reqs.pop_front());
			awaited_rsps.push_back(heap_outcome(req));
			sent <= sent + 1;
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				req <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end else if (!start && pending_reqs.size() != 0 &&
		             $urandom_range(0, 99) >= sender_idle_pct) begin
			start <= 1'b1;
			req   <= pending_reqs[0];
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			if (awaited_rsps.size() == 0) begin
				$error("unexpected result item: %p", rsp);
				errors++;
			end else begin
				rsp_item_t e;
				e = awaited_rsps.pop_front();
				checked++;
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.out_key !== e.out_key) begin
					$error("out_key: expected %0d, got %0d", e.out_key, rsp.out_key);
					errors++;
				end
				if (rsp.out_value !== e.out_value) begin
					$error("out_value: expected %0d, got %0d", e.out_value, rsp.out_value);
					errors++;
				end
				if (rsp.key_held !== e.key_held) begin
					$error("key_held: expected %0d, got %0d", e.key_held, rsp.key_held);
					errors++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count,
					       rsp.entry_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || rsp_valid || stim_done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no item accepted for %0d cycles", WatchdogLimit);
			$display("tb_indexed_min_priority_queue_unit: done, errors");
			$finish;
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		errors = 0;
		sent = 0;
		checked = 0;
		quiet_cycles = 0;
		stim_done = 0;
		sender_idle_pct = 0;
		heap_count = 0;
		foreach (held_key[n]) held_key[n] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty heap, extremes, duplicates, absent keys, no-op changes and ties.
		pending_reqs.push_back(make_req(REQ_POLL, 9, 0));
		pending_reqs.push_back(make_req(REQ_PEEK, 255, 0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 0, 0));
		pending_reqs.push_back(make_req(REQ_DELETE, 255, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 255, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(REQ_INSERT, 0, 32'h8000_0000));
		pending_reqs.push_back(make_req(REQ_INSERT, 170, 32'h5555_5555));
		pending_reqs.push_back(make_req(REQ_INSERT, 85, 32'haaaa_aaaa));
		pending_reqs.push_back(make_req(REQ_INSERT, 7, 32'h5555_5555));
		pending_reqs.push_back(make_req(REQ_INSERT, 0, 1));
		pending_reqs.push_back(make_req(REQ_UPDATE, 3, 1));
		pending_reqs.push_back(make_req(REQ_DECREASE, 255, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(REQ_INCREASE, 0, 32'h8000_0000));
		pending_reqs.push_back(make_req(REQ_DECREASE, 255, -5));
		pending_reqs.push_back(make_req(REQ_INCREASE, 0, 32'h7fff_fffe));
		pending_reqs.push_back(make_req(REQ_UPDATE, 85, 32'h5555_5555));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 170, 0));
		pending_reqs.push_back(make_req(REQ_PEEK, 0, 0));
		pending_reqs.push_back(make_req(REQ_POLL, 0, 0));
		pending_reqs.push_back(make_req(REQ_DELETE, 7, 0));
		pending_reqs.push_back(make_req(REQ_INCREASE, 4, 0));
		pending_reqs.push_back(make_req(REQ_POLL, 0, 0));
		pending_reqs.push_back(make_req(REQ_POLL, 0, 0));
		pending_reqs.push_back(make_req(REQ_POLL, 0, 0));
		pending_reqs.push_back(make_req(REQ_POLL, 0, 0));
		run_phase(0);

		add_random(450, 40);
		run_phase(0);
		add_random(450, 255);
		run_phase(53);
		// Fill the heap completely, then work on a full heap.
		for (i = 0; i < NumKeys; i++)
			pending_reqs.push_back(make_req(REQ_INSERT, i, rand_value()));
		add_random(150, 255);
		run_phase(17);
		add_random(450, 20);
		run_phase(53);

		stim_done = 1;
		repeat (200) @(posedge clk);
		$display("Sent %0d request items and checked %0d result items.", sent, checked);
		$display("Covered empty, partial and full heaps with random sender gaps.");
		if (errors == 0 && awaited_rsps.size() == 0)
			$display("tb_indexed_min_priority_queue_unit: done, clean");
		else
			$display("tb_indexed_min_priority_queue_unit: done, errors");
		$finish;
	end

endmodule
